@@ design/assert_macros.svh @@
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ design/are_pkg.sv @@
// Package with the types and constants of the array range engine.
`default_nettype none

package are_pkg;

    localparam int DEPTH_DEF     = 1024;
    localparam int WORD_BITS_DEF = 32;
    localparam int IDX_W         = 11;
    localparam int VAL_W         = 32;
    localparam int CMD_W         = 4;
    localparam int CUR_W         = 18;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 4'd0,
        CMD_READ    = 4'd1,
        CMD_SWAP    = 4'd2,
        CMD_LO_EQ   = 4'd3,
        CMD_LO_NE   = 4'd4,
        CMD_HI_EQ   = 4'd5,
        CMD_HI_NE   = 4'd6,
        CMD_REVERSE = 4'd7,
        CMD_SHR     = 4'd8,
        CMD_SHL     = 4'd9
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RD_WAIT,
        ST_PAIR_CHK,
        ST_PAIR_RA,
        ST_PAIR_RB,
        ST_PAIR_WA,
        ST_PAIR_WB,
        ST_S_RD,
        ST_S_CHK,
        ST_SH_RD,
        ST_SH_WR,
        ST_FIN
    } state_t;

    typedef logic signed [CUR_W-1:0] cur_t;

    // Widen an unsigned index into a signed cursor.
    function automatic cur_t widen(logic [IDX_W-1:0] x);
        return cur_t'({{(CUR_W-IDX_W){1'b0}}, x});
    endfunction

endpackage

`default_nettype wire

@@ design/are_req_if.sv @@
// Request channel of the array range engine.
`default_nettype none

interface are_req_if;
    logic                              valid;
    logic                              ready;
    logic [are_pkg::CMD_W-1:0]         req_type;
    logic [are_pkg::IDX_W-1:0]         first_index;
    logic [are_pkg::IDX_W-1:0]         second_index;
    logic [are_pkg::IDX_W-1:0]         shift_amount;
    logic signed [are_pkg::VAL_W-1:0]  value;

    modport source (output valid, req_type, first_index, second_index, shift_amount, value,
                    input ready);
    modport sink   (input valid, req_type, first_index, second_index, shift_amount, value,
                    output ready);
endinterface

`default_nettype wire

@@ design/are_rsp_if.sv @@
// Result channel of the array range engine.
`default_nettype none

interface are_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic [are_pkg::IDX_W-1:0]         position;
    logic signed [are_pkg::VAL_W-1:0]  read_data;

    modport source (output valid, found, position, read_data, input ready);
    modport sink   (input valid, found, position, read_data, output ready);
endinterface

`default_nettype wire

@@ design/array_range_engine.sv @@
// Top level of the array range engine: word store and command sequencer.
//
//  channel | dir | payload
//  req     | in  | req_type, first_index, second_index, shift_amount, value
//  rsp     | out | found, position, read_data
//
// Searches scan the range entry by entry, shifts move it entry by entry and
// reverse swaps it pair by pair; an index or pair outside the store is
// skipped without a store access. The sequencer makes one store access per
// cycle at most, and the store read is registered.
// Reset clears the sequencer and the result valid; the store is not cleared.
// A new request is taken while a finished result waits in the output register.
`default_nettype none

module array_range_engine #(
    parameter int DEPTH     = are_pkg::DEPTH_DEF,
    parameter int WORD_BITS = are_pkg::WORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    are_req_if.sink    req,
    are_rsp_if.source  rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam are_pkg::cur_t DEPTH_C = are_pkg::cur_t'(DEPTH);
    localparam are_pkg::cur_t ONE_C   = are_pkg::cur_t'(1);

    are_pkg::state_t state_reg, state_next;
    are_pkg::cmd_t   cmd_reg, cmd_next;

    logic [are_pkg::IDX_W-1:0] lo_reg, lo_next, hi_reg, hi_next, amt_reg, amt_next;
    logic [WORD_BITS-1:0]      key_reg, key_next, tmp_reg, tmp_next, rdata_reg;
    are_pkg::cur_t             a_reg, a_next, b_reg, b_next;

    logic                      res_found_reg, res_found_next;
    logic [are_pkg::IDX_W-1:0] res_pos_reg, res_pos_next;
    logic [are_pkg::VAL_W-1:0] res_rd_reg, res_rd_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      out_found_reg, out_found_next;
    logic [are_pkg::IDX_W-1:0] out_pos_reg, out_pos_next;
    logic [are_pkg::VAL_W-1:0] out_rd_reg, out_rd_next;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    are_pkg::cur_t lo_c, hi_c, amt_c, a_off, b_off;
    logic [AW-1:0] a_addr, b_addr;
    logic          a_in, b_in, empty, from_hi, want_eq, srch_last, sh_last, pair_go;
    logic          match, slot_free;
    logic [63:0]   val_ext, rd_ext;

    // Decode the held request
    assign lo_c      = are_pkg::widen(lo_reg);
    assign hi_c      = are_pkg::widen(hi_reg);
    assign amt_c     = are_pkg::widen(amt_reg);
    assign a_in      = (a_reg >= ONE_C) && (a_reg <= DEPTH_C);
    assign b_in      = (b_reg >= ONE_C) && (b_reg <= DEPTH_C);
    assign a_off     = a_reg - ONE_C;
    assign b_off     = b_reg - ONE_C;
    assign a_addr    = a_off[AW-1:0];
    assign b_addr    = b_off[AW-1:0];
    assign empty     = lo_c > hi_c;
    assign from_hi   = (cmd_reg == are_pkg::CMD_HI_EQ) || (cmd_reg == are_pkg::CMD_HI_NE);
    assign want_eq   = (cmd_reg == are_pkg::CMD_LO_EQ) || (cmd_reg == are_pkg::CMD_HI_EQ);
    assign srch_last = from_hi ? (a_reg == lo_c) : (a_reg == hi_c);
    assign sh_last   = (cmd_reg == are_pkg::CMD_SHR) ? (a_reg == lo_c) : (a_reg == hi_c);
    assign pair_go   = a_reg < b_reg;
    assign match     = ((rdata_reg == key_reg) == want_eq);
    assign slot_free = !out_valid_reg || rsp.ready;
    assign val_ext   = {{32{req.value[31]}}, req.value};
    assign rd_ext    = 64'(rdata_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            are_pkg::ST_IDLE:
            begin
                if (req.valid)
                    state_next = are_pkg::ST_DISPATCH;
            end
            are_pkg::ST_DISPATCH:
            begin
                unique case (cmd_reg)
                    are_pkg::CMD_WRITE:   state_next = are_pkg::ST_FIN;
                    are_pkg::CMD_READ:
                        state_next = a_in ? are_pkg::ST_RD_WAIT : are_pkg::ST_FIN;
                    are_pkg::CMD_SWAP:
                        state_next = (a_in && b_in) ? are_pkg::ST_PAIR_RA : are_pkg::ST_FIN;
                    are_pkg::CMD_REVERSE: state_next = are_pkg::ST_PAIR_CHK;
                    are_pkg::CMD_LO_EQ, are_pkg::CMD_LO_NE,
                    are_pkg::CMD_HI_EQ, are_pkg::CMD_HI_NE:
                        state_next = empty ? are_pkg::ST_FIN : are_pkg::ST_S_RD;
                    are_pkg::CMD_SHR, are_pkg::CMD_SHL:
                        state_next = empty ? are_pkg::ST_FIN : are_pkg::ST_SH_RD;
                    default:              state_next = are_pkg::ST_FIN;
                endcase
            end
            are_pkg::ST_RD_WAIT: state_next = are_pkg::ST_FIN;
            are_pkg::ST_PAIR_CHK:
            begin
                if (!pair_go)
                    state_next = are_pkg::ST_FIN;
                else if (a_in && b_in)
                    state_next = are_pkg::ST_PAIR_RA;
            end
            are_pkg::ST_PAIR_RA: state_next = are_pkg::ST_PAIR_RB;
            are_pkg::ST_PAIR_RB: state_next = are_pkg::ST_PAIR_WA;
            are_pkg::ST_PAIR_WA: state_next = are_pkg::ST_PAIR_WB;
            are_pkg::ST_PAIR_WB:
                state_next = (cmd_reg == are_pkg::CMD_SWAP) ? are_pkg::ST_FIN
                                                            : are_pkg::ST_PAIR_CHK;
            are_pkg::ST_S_RD:
            begin
                if (a_in)
                    state_next = are_pkg::ST_S_CHK;
                else if (srch_last)
                    state_next = are_pkg::ST_FIN;
            end
            are_pkg::ST_S_CHK:
                state_next = (match || srch_last) ? are_pkg::ST_FIN : are_pkg::ST_S_RD;
            are_pkg::ST_SH_RD:
            begin
                if (a_in && b_in)
                    state_next = are_pkg::ST_SH_WR;
                else if (sh_last)
                    state_next = are_pkg::ST_FIN;
            end
            are_pkg::ST_SH_WR:
                state_next = sh_last ? are_pkg::ST_FIN : are_pkg::ST_SH_RD;
            are_pkg::ST_FIN:
            begin
                if (slot_free)
                    state_next = are_pkg::ST_IDLE;
            end
            default: state_next = are_pkg::ST_IDLE;
        endcase
    end

    // Datapath, store accesses and result
    always_comb
    begin
        cmd_next       = cmd_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        amt_next       = amt_reg;
        key_next       = key_reg;
        tmp_next       = tmp_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        res_rd_next    = res_rd_reg;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        out_rd_next    = out_rd_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = a_addr;
        mem_raddr      = a_addr;
        mem_wdata      = key_reg;
        unique case (state_reg)
            are_pkg::ST_IDLE:
            begin
                // Take the request
                if (req.valid)
                begin
                    cmd_next       = are_pkg::cmd_t'(req.req_type);
                    lo_next        = req.first_index;
                    hi_next        = req.second_index;
                    amt_next       = req.shift_amount;
                    key_next       = val_ext[WORD_BITS-1:0];
                    a_next         = are_pkg::widen(req.first_index);
                    b_next         = are_pkg::widen(req.second_index);
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    res_rd_next    = '0;
                end
            end
            are_pkg::ST_DISPATCH:
            begin
                unique case (cmd_reg)
                    are_pkg::CMD_WRITE: mem_we = a_in;
                    are_pkg::CMD_READ:  mem_re = a_in;
                    are_pkg::CMD_LO_EQ, are_pkg::CMD_LO_NE:
                    begin
                        if (empty)
                            res_pos_next = hi_reg + 1'b1;
                    end
                    are_pkg::CMD_HI_EQ, are_pkg::CMD_HI_NE:
                    begin
                        a_next = hi_c;
                        if (empty)
                            res_pos_next = lo_reg - 1'b1;
                    end
                    are_pkg::CMD_SHR:
                    begin
                        a_next = hi_c;
                        b_next = hi_c + amt_c;
                    end
                    are_pkg::CMD_SHL:
                    begin
                        a_next = lo_c;
                        b_next = lo_c - amt_c;
                    end
                    default: ;
                endcase
            end
            are_pkg::ST_RD_WAIT: res_rd_next = rd_ext[31:0];
            are_pkg::ST_PAIR_CHK:
            begin
                // Skip a pair with an end outside the store
                if (pair_go && !(a_in && b_in))
                begin
                    a_next = a_reg + ONE_C;
                    b_next = b_reg - ONE_C;
                end
            end
            are_pkg::ST_PAIR_RA: mem_re = 1'b1;
            are_pkg::ST_PAIR_RB:
            begin
                mem_re    = 1'b1;
                mem_raddr = b_addr;
                tmp_next  = rdata_reg;
            end
            are_pkg::ST_PAIR_WA:
            begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
            end
            are_pkg::ST_PAIR_WB:
            begin
                mem_we    = 1'b1;
                mem_waddr = b_addr;
                mem_wdata = tmp_reg;
                a_next    = a_reg + ONE_C;
                b_next    = b_reg - ONE_C;
            end
            are_pkg::ST_S_RD:
            begin
                if (a_in)
                    mem_re = 1'b1;
                else if (srch_last)
                    res_pos_next = from_hi ? lo_reg - 1'b1 : hi_reg + 1'b1;
                else
                    a_next = from_hi ? a_reg - ONE_C : a_reg + ONE_C;
            end
            are_pkg::ST_S_CHK:
            begin
                if (match)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = a_reg[are_pkg::IDX_W-1:0];
                end
                else if (srch_last)
                    res_pos_next = from_hi ? lo_reg - 1'b1 : hi_reg + 1'b1;
                else
                    a_next = from_hi ? a_reg - ONE_C : a_reg + ONE_C;
            end
            are_pkg::ST_SH_RD:
            begin
                if (a_in && b_in)
                    mem_re = 1'b1;
                else if (!sh_last)
                begin
                    a_next = (cmd_reg == are_pkg::CMD_SHR) ? a_reg - ONE_C : a_reg + ONE_C;
                    b_next = (cmd_reg == are_pkg::CMD_SHR) ? b_reg - ONE_C : b_reg + ONE_C;
                end
            end
            are_pkg::ST_SH_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = b_addr;
                mem_wdata = rdata_reg;
                if (!sh_last)
                begin
                    a_next = (cmd_reg == are_pkg::CMD_SHR) ? a_reg - ONE_C : a_reg + ONE_C;
                    b_next = (cmd_reg == are_pkg::CMD_SHR) ? b_reg - ONE_C : b_reg + ONE_C;
                end
            end
            are_pkg::ST_FIN:
            begin
                // Hand the result to the output register once it is free
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_pos_next   = res_pos_reg;
                    out_rd_next    = res_rd_reg;
                end
            end
            default: ;
        endcase
    end

    // Word store with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= are_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        amt_reg       <= amt_next;
        key_reg       <= key_next;
        tmp_reg       <= tmp_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        res_rd_reg    <= res_rd_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
        out_rd_reg    <= out_rd_next;
    end

    assign req.ready     = (state_reg == are_pkg::ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.found     = out_found_reg;
    assign rsp.position  = out_pos_reg;
    assign rsp.read_data = out_rd_reg;

endmodule

`default_nettype wire

@@ design/are_checker.sv @@
// Port checker for the array range engine and its bind.
`default_nettype none
`include "assert_macros.svh"

module are_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        found,
    input logic [are_pkg::IDX_W-1:0]   position,
    input logic [are_pkg::VAL_W-1:0]   read_data
);

    logic [1:0] pend_reg, pend_next;
    logic       in_acc, out_acc;
    logic [are_pkg::IDX_W+are_pkg::VAL_W:0] rsp_payload;

    assign in_acc      = in_valid && in_ready;
    assign out_acc     = out_valid && out_ready;
    assign rsp_payload = {found, position, read_data};

    // Count requests whose result is not yet taken
    always_comb
    begin
        pend_next = pend_reg + 2'(in_acc) - 2'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    `ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `ASSERT_NEXT(a_rsp_stable, out_valid && !out_ready, $stable(rsp_payload), "result changed")
    `ASSERT_NEXT(a_busy_after_req, in_acc, !in_ready, "request taken on consecutive cycles")
    `ASSERT_CLK(a_no_invented, !out_valid || (pend_reg != 2'd0), "result without request")
    `ASSERT_CLK(a_pend_bound, pend_reg != 2'd3, "more than two requests outstanding")

endmodule

bind array_range_engine are_checker u_are_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .found     (rsp.found),
    .position  (rsp.position),
    .read_data (rsp.read_data)
);

`default_nettype wire
